@@ rtl/crfp_pkg.sv @@
// Shared types and constants for the radio-control frame packer.
// No dependencies; used by crfp_store, crfp_serialiser and the top level.
`default_nettype none

package crfp_pkg;

    // Input item field widths
    localparam int KIND_W    = 2;
    localparam int CHANNEL_W = 4;
    localparam int VALUE_W   = 11;
    localparam int FLAGS_W   = 8;
    localparam int S_TDATA_W = 24;   // channel + value + flag_bits, padded to bytes
    localparam int BYTE_W    = 8;

    // Item kinds carried on s_tuser
    localparam logic [KIND_W-1:0] KIND_SET_CHANNEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET_FLAGS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK        = 2'd2;

    // Frame layout
    localparam logic [BYTE_W-1:0]  FRAME_HEADER = 8'h0F;
    localparam logic [BYTE_W-1:0]  FRAME_FOOTER = 8'h00;
    localparam logic [VALUE_W-1:0] CENTER_VALUE = 11'd992;
    localparam int DATA_BYTES  = 22;
    localparam int STREAM_BITS = DATA_BYTES * BYTE_W;
    localparam int CNT_W       = 5;

    // Byte positions within a frame
    localparam logic [CNT_W-1:0] POS_HEADER     = 5'd0;
    localparam logic [CNT_W-1:0] POS_FIRST_DATA = 5'd1;
    localparam logic [CNT_W-1:0] POS_LAST_DATA  = 5'd22;
    localparam logic [CNT_W-1:0] POS_FLAGS      = 5'd23;
    localparam logic [CNT_W-1:0] POS_FOOTER     = 5'd24;

    // Decoded commands from the input channel to the channel store
    typedef struct packed {
        logic set_channel;
        logic set_flags;
        logic tick;
    } store_cmd_t;

endpackage

`default_nettype wire

@@ rtl/crfp_store.sv @@
// Pending and sent copies of the channel values and the flags byte.
// Depends on crfp_pkg; feeds the frame bit stream to crfp_serialiser.
`default_nettype none

module crfp_store #(
    parameter int NUM_CHANNELS  = 16,
    parameter int CHANNEL_WIDTH = 11
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire crfp_pkg::store_cmd_t                cmd,
    input  wire logic [crfp_pkg::CHANNEL_W-1:0]      channel,
    input  wire logic [crfp_pkg::VALUE_W-1:0]        value,
    input  wire logic [crfp_pkg::FLAGS_W-1:0]        flag_bits,
    output logic      [crfp_pkg::STREAM_BITS-1:0]    frame_bits,
    output logic      [crfp_pkg::FLAGS_W-1:0]        frame_flags
);

    localparam int STREAM_LEN = NUM_CHANNELS * CHANNEL_WIDTH;

    logic [CHANNEL_WIDTH-1:0] pending_reg [NUM_CHANNELS];
    logic [CHANNEL_WIDTH-1:0] sent_reg    [NUM_CHANNELS];
    logic [crfp_pkg::FLAGS_W-1:0] pending_flags_reg;
    logic [crfp_pkg::FLAGS_W-1:0] sent_flags_reg;
    logic                         mark_reg;
    logic                         ch_in_range;
    logic [STREAM_LEN-1:0]        src_flat;

    assign ch_in_range = ({1'b0, channel} < (crfp_pkg::CHANNEL_W + 1)'(NUM_CHANNELS));

    // The frame goes out from what sent will hold after this tick
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            src_flat[i*CHANNEL_WIDTH +: CHANNEL_WIDTH] = mark_reg ? pending_reg[i] : sent_reg[i];
        end
        frame_flags = mark_reg ? pending_flags_reg : sent_flags_reg;
    end

    // Fit the channel stream to the data bytes: zero above it, drop beyond them
    for (genvar b = 0; b < crfp_pkg::STREAM_BITS; b++) begin : g_fit
        if (b < STREAM_LEN) begin : g_bit
            assign frame_bits[b] = src_flat[b];
        end else begin : g_zero
            assign frame_bits[b] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                pending_reg[i] <= CHANNEL_WIDTH'(crfp_pkg::CENTER_VALUE);
                sent_reg[i]    <= '0;
            end
            pending_flags_reg <= '0;
            sent_flags_reg    <= '0;
            mark_reg          <= 1'b1;
        end else begin
            if (cmd.set_channel && ch_in_range) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (channel == crfp_pkg::CHANNEL_W'(i)) begin
                        pending_reg[i] <= CHANNEL_WIDTH'(value);
                    end
                end
                mark_reg <= 1'b1;
            end
            if (cmd.set_flags) begin
                pending_flags_reg <= flag_bits;
            end
            if (cmd.tick && mark_reg) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    sent_reg[i] <= pending_reg[i];
                end
                sent_flags_reg <= pending_flags_reg;
                mark_reg       <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/crfp_serialiser.sv @@
// Byte-serial frame emitter: header, data bytes shifted out one byte a cycle, flags, footer,
// through a registered output stage that m_tready can stall. Depends on crfp_pkg.
`default_nettype none

module crfp_serialiser (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [crfp_pkg::STREAM_BITS-1:0]    frame_bits,
    input  wire logic [crfp_pkg::FLAGS_W-1:0]        frame_flags,
    output logic                                     ready,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [crfp_pkg::BYTE_W-1:0]         m_tdata,
    output logic                                     m_tlast
);

    logic                               busy_reg;
    logic [crfp_pkg::CNT_W-1:0]         cnt_reg;
    logic [crfp_pkg::STREAM_BITS-1:0]   shift_reg;
    logic [crfp_pkg::FLAGS_W-1:0]       flags_reg;
    logic                               m_tvalid_reg;
    logic [crfp_pkg::BYTE_W-1:0]        m_tdata_reg;
    logic                               m_tlast_reg;

    logic                               advance;
    logic                               finishing;
    logic                               in_data;
    logic [crfp_pkg::BYTE_W-1:0]        byte_next;

    always_comb begin
        advance   = busy_reg && (!m_tvalid_reg || m_tready);
        finishing = advance && (cnt_reg == crfp_pkg::POS_FOOTER);
        in_data   = (cnt_reg >= crfp_pkg::POS_FIRST_DATA) && (cnt_reg <= crfp_pkg::POS_LAST_DATA);
        ready     = !busy_reg || finishing;
        case (cnt_reg)
            crfp_pkg::POS_HEADER: byte_next = crfp_pkg::FRAME_HEADER;
            crfp_pkg::POS_FLAGS:  byte_next = flags_reg;
            crfp_pkg::POS_FOOTER: byte_next = crfp_pkg::FRAME_FOOTER;
            default:              byte_next = shift_reg[crfp_pkg::BYTE_W-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= crfp_pkg::POS_HEADER;
            end else if (finishing) begin
                busy_reg <= 1'b0;
            end else if (advance) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= frame_bits;
            flags_reg <= frame_flags;
        end else if (advance && in_data) begin
            shift_reg <= {{crfp_pkg::BYTE_W{1'b0}},
                          shift_reg[crfp_pkg::STREAM_BITS-1:crfp_pkg::BYTE_W]};
        end
        if (advance) begin
            m_tdata_reg <= byte_next;
            m_tlast_reg <= (cnt_reg == crfp_pkg::POS_FOOTER);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_footer_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg) |-> (m_tdata_reg == crfp_pkg::FRAME_FOOTER))
        else $error("footer byte not zero");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (!busy_reg || finishing))
        else $error("frame started while one is in progress");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg <= crfp_pkg::POS_FOOTER))
        else $error("byte position out of frame");

    a_idle_after_footer: assert property (@(posedge aclk) disable iff (!aresetn)
        (finishing && !start) |=> !busy_reg)
        else $error("still busy after footer");

endmodule

`default_nettype wire

@@ rtl/rc_channel_frame_packer.sv @@
// Radio-control frame packer: 16 channels of 11 bits into 25-byte frames.
// A tick item sets the serialiser busy; the header byte then leaves through the registered output stage.
// Frames go out one byte per cycle while m_tready is high; data bytes come from the byte shift register.
// Set-channel and set-flags items are accepted when no frame is out or as its footer leaves.
// Reset (aresetn low, synchronous): pending channels centred, sent copies zero,
// update marked, no frame in progress.
`default_nettype none

module rc_channel_frame_packer #(
    parameter int NUM_CHANNELS  = 16,
    parameter int CHANNEL_WIDTH = 11
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [crfp_pkg::S_TDATA_W-1:0]     s_tdata,  // channel[3:0], value[14:4],
                                                              // flag_bits[22:15], zero[23]
    input  wire logic [crfp_pkg::KIND_W-1:0]        s_tuser,  // kind[1:0]
    // Result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [crfp_pkg::BYTE_W-1:0]        m_tdata,  // out_byte[7:0]
    output logic                                    m_tlast   // last_byte
);

    localparam int VALUE_LO = crfp_pkg::CHANNEL_W;
    localparam int FLAGS_LO = crfp_pkg::CHANNEL_W + crfp_pkg::VALUE_W;

    logic                                   accept;
    crfp_pkg::store_cmd_t                   cmd;
    logic [crfp_pkg::CHANNEL_W-1:0]         channel;
    logic [crfp_pkg::VALUE_W-1:0]           value;
    logic [crfp_pkg::FLAGS_W-1:0]           flag_bits;
    logic [crfp_pkg::STREAM_BITS-1:0]       frame_bits;
    logic [crfp_pkg::FLAGS_W-1:0]           frame_flags;
    logic                                   ser_ready;

    // Unpack the item fields
    assign channel   = s_tdata[crfp_pkg::CHANNEL_W-1:0];
    assign value     = s_tdata[VALUE_LO +: crfp_pkg::VALUE_W];
    assign flag_bits = s_tdata[FLAGS_LO +: crfp_pkg::FLAGS_W];

    // Hold off items while a frame goes out; free again as the footer leaves
    assign s_tready = ser_ready;
    assign accept   = s_tvalid && s_tready;

    // Decode the kind; the unused kind drops through with no effect
    always_comb begin
        cmd.set_channel = accept && (s_tuser == crfp_pkg::KIND_SET_CHANNEL);
        cmd.set_flags   = accept && (s_tuser == crfp_pkg::KIND_SET_FLAGS);
        cmd.tick        = accept && (s_tuser == crfp_pkg::KIND_TICK);
    end

    // Pending and sent copies; presents the stream the frame will carry
    crfp_store #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .CHANNEL_WIDTH (CHANNEL_WIDTH)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .channel     (channel),
        .value       (value),
        .flag_bits   (flag_bits),
        .frame_bits  (frame_bits),
        .frame_flags (frame_flags)
    );

    // Load the stream on a tick and shift it out byte by byte
    crfp_serialiser u_serialiser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (cmd.tick),
        .frame_bits  (frame_bits),
        .frame_flags (frame_flags),
        .ready       (ser_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

@@ sim/rc_channel_frame_packer_test.sv @@
// Self-checking testbench for rc_channel_frame_packer: drives channel, flags and tick items
// and checks every frame byte against a behavioural copy of the pending/sent channel store.
// Depends on crfp_pkg and the rc_channel_frame_packer RTL.

module rc_channel_frame_packer_test;

    localparam logic [crfp_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;   // no meaning, block drops it
    localparam int NUM_CH       = 16;
    localparam int CH_W         = 11;
    localparam int FRAME_LEN    = 25;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int IDLE_LIMIT   = 2000;   // cycles without any handshake before giving up
    localparam int SETTLE       = 30;     // quiet cycles after the last byte
    localparam int RANDOM_ITEMS = 330;

    typedef struct packed {
        logic [crfp_pkg::BYTE_W-1:0] data;
        logic                        last;
    } frame_byte_t;

    typedef struct {
        logic [crfp_pkg::KIND_W-1:0]    kind;
        logic [crfp_pkg::CHANNEL_W-1:0] channel;
        logic [crfp_pkg::VALUE_W-1:0]   value;
        logic [crfp_pkg::FLAGS_W-1:0]   flags;
        bit                             typed;       // expected frame written into the row
        logic [crfp_pkg::BYTE_W-1:0]    fill;        // every data byte of a typed frame
        logic [crfp_pkg::FLAGS_W-1:0]   want_flags;  // flags byte of a typed frame
    } stim_row_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [crfp_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [crfp_pkg::KIND_W-1:0]    s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [crfp_pkg::BYTE_W-1:0]    m_tdata;
    logic                           m_tlast;

    rc_channel_frame_packer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Behavioural channel store
    logic [CH_W-1:0]              pending_ch [NUM_CH];
    logic [CH_W-1:0]              sent_ch    [NUM_CH];
    logic [crfp_pkg::FLAGS_W-1:0] pending_flags;
    logic [crfp_pkg::FLAGS_W-1:0] sent_flags;
    bit                           update_marked;

    frame_byte_t frame_bytes_q[$];   // bytes still owed by the block, oldest first
    stim_row_t   directed_rows[$];

    int  errors      = 0;
    int  n_bytes     = 0;
    int  n_ticks     = 0;
    int  n_chan_sets = 0;
    int  n_flag_sets = 0;
    int  n_ignored   = 0;
    int  idle_cycles = 0;
    bit  tx_burst    = 1'b0;   // sender offers items back to back
    bit  rx_burst    = 1'b0;   // receiver takes bytes back to back
    bit  hold_rx     = 1'b0;   // ask the receiver for a long hold-off

    // Bit j of data byte m is bit 8m+j of channel 0, channel 1, ... laid end to end
    function automatic logic [crfp_pkg::BYTE_W-1:0] stream_byte(input int m);
        logic [crfp_pkg::BYTE_W-1:0] b;
        int                          bit_idx;
        b = '0;
        for (int j = 0; j < crfp_pkg::BYTE_W; j++) begin
            bit_idx = m * crfp_pkg::BYTE_W + j;
            if (bit_idx / CH_W < NUM_CH)
                b[j] = sent_ch[bit_idx / CH_W][bit_idx % CH_W];
        end
        return b;
    endfunction

    // Queue the 25 bytes of one frame; typed rows supply the data fill and flags themselves
    function void queue_frame(input stim_row_t r);
        frame_byte_t fb;
        for (int k = 0; k < FRAME_LEN; k++) begin
            if (k == crfp_pkg::POS_HEADER)
                fb.data = crfp_pkg::FRAME_HEADER;
            else if (k <= crfp_pkg::POS_LAST_DATA)
                fb.data = r.typed ? r.fill : stream_byte(k - 1);
            else if (k == crfp_pkg::POS_FLAGS)
                fb.data = r.typed ? r.want_flags : sent_flags;
            else
                fb.data = crfp_pkg::FRAME_FOOTER;
            fb.last = (k == crfp_pkg::POS_FOOTER);
            frame_bytes_q.push_back(fb);
        end
    endfunction

    // Advance the store by one accepted item
    function void packer_accept(input stim_row_t r);
        case (r.kind)
            crfp_pkg::KIND_SET_CHANNEL: begin
                if (r.channel < NUM_CH) begin
                    pending_ch[r.channel] = r.value;
                    update_marked = 1'b1;
                end
                n_chan_sets++;
            end
            crfp_pkg::KIND_SET_FLAGS: begin
                pending_flags = r.flags;
                n_flag_sets++;
            end
            crfp_pkg::KIND_TICK: begin
                // latch pending into sent only while an update is marked (after reset or a channel write)
                if (update_marked) begin
                    sent_ch       = pending_ch;
                    sent_flags    = pending_flags;
                    update_marked = 1'b0;
                end
                queue_frame(r);
                n_ticks++;
            end
            default: n_ignored++;
        endcase
    endfunction

    task report(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    task add_row(input logic [crfp_pkg::KIND_W-1:0] kind, input int channel, input int value,
                 input int flags, input bit typed, input int fill, input int want_flags);
        stim_row_t r;
        r.kind       = kind;
        r.channel    = channel[crfp_pkg::CHANNEL_W-1:0];
        r.value      = value[crfp_pkg::VALUE_W-1:0];
        r.flags      = flags[crfp_pkg::FLAGS_W-1:0];
        r.typed      = typed;
        r.fill       = fill[crfp_pkg::BYTE_W-1:0];
        r.want_flags = want_flags[crfp_pkg::FLAGS_W-1:0];
        directed_rows.push_back(r);
    endtask

    // Random item; values lean on both ends of the channel range
    function stim_row_t random_row();
        stim_row_t r;
        int        roll;
        int        ch;
        int        v;
        int        fl;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            r.kind = KIND_UNUSED;
        else if (roll < 55)
            r.kind = crfp_pkg::KIND_SET_CHANNEL;
        else if (roll < 68)
            r.kind = crfp_pkg::KIND_SET_FLAGS;
        else
            r.kind = crfp_pkg::KIND_TICK;
        ch        = $urandom_range(0, NUM_CH - 1);
        r.channel = ch[crfp_pkg::CHANNEL_W-1:0];
        case ($urandom_range(0, 3))
            0:       r.value = '0;
            1:       r.value = '1;
            default: begin
                v       = $urandom_range(0, (1 << crfp_pkg::VALUE_W) - 1);
                r.value = v[crfp_pkg::VALUE_W-1:0];
            end
        endcase
        fl           = $urandom_range(0, 255);
        r.flags      = fl[crfp_pkg::FLAGS_W-1:0];
        r.typed      = 1'b0;
        r.fill       = '0;
        r.want_flags = '0;
        return r;
    endfunction

    // Offer one item after a random gap, hold it until taken, then update the store
    task send_item(input stim_row_t r);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {1'b0, r.flags, r.value, r.channel};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        packer_accept(r);
    endtask

    // Withdraw the sender and hold it until every owed byte has come out
    task drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frame_bytes_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random gap per byte, bursts at times, one long hold-off on request
    initial begin : receiver
        int gap;
        int taken;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end
            if (taken % 50 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    // Check each byte against the oldest one owed
    always @(posedge aclk) begin : byte_check
        frame_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_bytes_q.size() == 0) begin
                report($sformatf("byte %0d (%h) with nothing owed", n_bytes, m_tdata));
            end else begin
                want = frame_bytes_q.pop_front();
                if (m_tdata !== want.data)
                    report($sformatf("byte %0d data %h, expected %h",
                                     n_bytes, m_tdata, want.data));
                if (m_tlast !== want.last)
                    report($sformatf("byte %0d last %b, expected %b",
                                     n_bytes, m_tlast, want.last));
            end
            n_bytes++;
        end
    end

    // Stop the run if nothing moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles = 0;
        else if (aresetn)
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d bytes owed",
                     idle_cycles, frame_bytes_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t r;
        int        counted;
        int        i;

        // store as it stands after reset: pending centred, sent zero, update marked
        for (int c = 0; c < NUM_CH; c++) begin
            pending_ch[c] = crfp_pkg::CENTER_VALUE;
            sent_ch[c]    = '0;
        end
        pending_flags = '0;
        sent_flags    = '0;
        update_marked = 1'b1;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // unused kind with every field at its top, then the centred frame twice
        add_row(KIND_UNUSED,               15, 2047, 8'hFF, 1'b0, 0, 0);
        add_row(crfp_pkg::KIND_TICK,        0,    0,     0, 1'b0, 0, 0);
        add_row(crfp_pkg::KIND_TICK,        0,    0,     0, 1'b0, 0, 0);
        // flags alone mark no update, so the next frame still carries the old flags
        add_row(crfp_pkg::KIND_SET_FLAGS,   0,    0, 8'hFF, 1'b0, 0, 0);
        add_row(crfp_pkg::KIND_TICK,        0,    0,     0, 1'b0, 0, 0);
        // zero every channel: all data bytes go to zero and the new flags follow
        for (int c = 0; c < NUM_CH; c++)
            add_row(crfp_pkg::KIND_SET_CHANNEL, c, 0, 0, 1'b0, 0, 0);
        add_row(crfp_pkg::KIND_TICK,        0,    0,     0, 1'b1, 8'h00, 8'hFF);
        // top value in the last channel fills the tail of the stream
        add_row(crfp_pkg::KIND_SET_CHANNEL, 15, 2047,    0, 1'b0, 0, 0);
        add_row(crfp_pkg::KIND_SET_FLAGS,   0,    0, 8'h00, 1'b0, 0, 0);
        add_row(crfp_pkg::KIND_TICK,        0,    0,     0, 1'b0, 0, 0);

        foreach (directed_rows[n])
            send_item(directed_rows[n]);
        drain();

        counted = 0;
        i       = 0;
        while (counted < RANDOM_ITEMS) begin
            if (i % 40 == 0)
                tx_burst = ($urandom_range(0, 2) == 0);
            if (i == 100) begin
                // hold the receiver off and keep offering frames until the input stalls
                hold_rx  = 1'b1;
                tx_burst = 1'b1;
                for (int b = 0; b < 6; b++) begin
                    r = random_row();
                    r.kind = (b % 2 == 0) ? crfp_pkg::KIND_TICK : crfp_pkg::KIND_SET_CHANNEL;
                    send_item(r);
                    counted++;
                end
                tx_burst = 1'b0;
            end
            if (i == 220)
                drain();
            r = random_row();
            send_item(r);
            if (r.kind != KIND_UNUSED)
                counted++;
            i++;
        end

        drain();
        repeat (SETTLE) @(posedge aclk);

        $display("items: %0d channel writes, %0d flags writes, %0d ticks, %0d unused kinds",
                 n_chan_sets, n_flag_sets, n_ticks, n_ignored);
        $display("frame bytes checked: %0d, mismatches: %0d", n_bytes, errors);
        if (errors == 0 && frame_bytes_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/crfp_pkg.sv
rtl/crfp_store.sv
rtl/crfp_serialiser.sv
rtl/rc_channel_frame_packer.sv
sim/rc_channel_frame_packer_test.sv
